>>> rtl/csem_pkg.sv
// shared types and constants for the counting semaphore with timed wait queue
// no dependencies; used by csem_front, csem_back and the top level
package csem_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TMO_W       = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEN_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_MAX   = 32767;

  // request opcodes
  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef enum logic [2:0] {
    K_GRANTED   = 3'd0,
    K_BLOCKED   = 3'd1,
    K_SIG_REL   = 3'd2,
    K_TMO_REL   = 3'd3,
    K_SIG_DONE  = 3'd4,
    K_TICK_DONE = 3'd5,
    K_ERROR     = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        thread_id;
    logic [15:0]       timeout_ticks;
    logic signed [7:0] signal_count;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         released_thread;
    logic [4:0]         released_total;
    logic signed [15:0] count_now;
    logic               last;
  } res_t;

  // classified command between front and back
  typedef enum logic [1:0] {
    C_WAIT,
    C_SIGNAL,
    C_TICK,
    C_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [3:0]       tid;
    logic [TMO_W-1:0] tmo;
    logic [6:0]       reps;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_SIG,
    S_TDEC,
    S_TREL,
    S_ERR
  } bk_state_t;

endpackage

>>> rtl/csem_front.sv
// front end: accepts requests, classifies them into commands, two-entry queue
// depends on csem_pkg
module csem_front import csem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t       cls;
  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  // classify the request
  always_comb begin
    cls.tid  = req.thread_id;
    cls.tmo  = req.timeout_ticks;
    cls.reps = (req.signal_count == 8'sd0) ? 7'd1 : req.signal_count[6:0];
    case (req.opcode)
      OP_WAIT:   cls.op = C_WAIT;
      OP_SIGNAL: cls.op = req.signal_count[7] ? C_ERROR : C_SIGNAL;
      OP_TICK:   cls.op = C_TICK;
      default:   cls.op = C_ERROR;
    endcase
  end

  // queue handshake
  assign req_ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = fifo[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cls;
  end

endmodule

>>> rtl/csem_back.sv
// back end: semaphore count, wait queue, release sequencer and result register
// depends on csem_pkg
module csem_back import csem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  bk_state_t          state;
  bk_state_t          state_next;
  cmd_t               cur;
  logic signed [15:0] count;
  logic signed [15:0] count_next;
  logic [QLEN_W-1:0]  qlen;
  logic [QLEN_W-1:0]  qlen_next;
  logic [3:0]         q_id  [QUEUE_DEPTH];
  logic [TMO_W-1:0]   q_tmo [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] expired;
  logic [6:0]         rem;
  logic [6:0]         rem_next;
  logic [4:0]         total;
  logic [4:0]         total_next;

  logic               can_emit;
  logic               emit;
  res_t               er;
  logic               do_push;
  logic               do_shift;
  logic               do_dec;
  logic [QIDX_W-1:0]  shift_idx;
  logic [QIDX_W-1:0]  first_idx;
  logic               any_exp;
  logic               sig_rel;
  logic signed [15:0] count_inc;
  logic signed [16:0] sig_sum;
  logic signed [15:0] count_bulk;

  assign can_emit = !res_valid || res_ready;
  assign any_exp  = |expired;
  assign sig_rel  = (rem != 7'd0) && (count < 16'sd0) && (qlen != '0);

  // saturating increments
  assign count_inc  = (count == 16'(COUNT_MAX)) ? count : count + 16'sd1;
  assign sig_sum    = {count[15], count} + $signed({10'd0, rem});
  assign count_bulk = (sig_sum > 17'sd32767) ? 16'(COUNT_MAX) : sig_sum[15:0];

  // oldest expired entry
  always_comb begin
    logic found;
    found     = 1'b0;
    first_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (expired[i] && !found) begin
        first_idx = QIDX_W'(i);
        found     = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            C_WAIT:   state_next = S_WAIT;
            C_SIGNAL: state_next = S_SIG;
            C_TICK:   state_next = S_TDEC;
            default:  state_next = S_ERR;
          endcase
        end
      end
      S_WAIT, S_ERR: if (can_emit) state_next = S_IDLE;
      S_SIG:  if (can_emit && !sig_rel) state_next = S_IDLE;
      S_TDEC: state_next = S_TREL;
      S_TREL: if (can_emit && !any_exp) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls and result build
  always_comb begin
    cmd_ready  = 1'b0;
    emit       = 1'b0;
    er         = '0;
    er.kind    = K_ERROR;
    count_next = count;
    qlen_next  = qlen;
    do_push    = 1'b0;
    do_shift   = 1'b0;
    do_dec     = 1'b0;
    shift_idx  = '0;
    rem_next   = rem;
    total_next = total;
    case (state)
      S_IDLE: cmd_ready = 1'b1;
      S_WAIT: begin
        if (can_emit) begin
          emit    = 1'b1;
          er.last = 1'b1;
          if (count > 16'sd0) begin
            count_next         = count - 16'sd1;
            er.kind            = K_GRANTED;
            er.released_thread = cur.tid;
          end else if (qlen < QLEN_W'(QUEUE_DEPTH)) begin
            count_next         = count - 16'sd1;
            do_push            = 1'b1;
            qlen_next          = qlen + QLEN_W'(1);
            er.kind            = K_BLOCKED;
            er.released_thread = cur.tid;
          end
        end
      end
      S_ERR: begin
        if (can_emit) begin
          emit    = 1'b1;
          er.last = 1'b1;
        end
      end
      S_SIG: begin
        if (can_emit) begin
          emit = 1'b1;
          if (sig_rel) begin
            er.kind            = K_SIG_REL;
            er.released_thread = q_id[0];
            do_shift           = 1'b1;
            qlen_next          = qlen - QLEN_W'(1);
            count_next         = count + 16'sd1;
            rem_next           = rem - 7'd1;
            total_next         = total + 5'd1;
          end else begin
            count_next        = count_bulk;
            er.kind           = K_SIG_DONE;
            er.released_total = total;
            er.last           = 1'b1;
          end
        end
      end
      S_TDEC: do_dec = 1'b1;
      S_TREL: begin
        if (can_emit) begin
          emit = 1'b1;
          if (any_exp) begin
            er.kind            = K_TMO_REL;
            er.released_thread = q_id[first_idx];
            do_shift           = 1'b1;
            shift_idx          = first_idx;
            qlen_next          = qlen - QLEN_W'(1);
            count_next         = count_inc;
          end else begin
            er.kind = K_TICK_DONE;
            er.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
    er.count_now = count_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= 16'sd1;
      qlen      <= '0;
      expired   <= '0;
      res_valid <= 1'b0;
    end else if (cfg_we) begin
      count   <= $signed({1'b0, cfg_wdata});
      qlen    <= '0;
      expired <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      qlen  <= qlen_next;
      if (emit)           res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (do_dec) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          expired[i] <= (i < int'(qlen)) && (q_tmo[i] == TMO_W'(1));
        end
      end else if (do_shift) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (j >= int'(shift_idx)) begin
            expired[j] <= (j == QUEUE_DEPTH - 1) ? 1'b0 : expired[j+1];
          end
        end
      end
    end
  end

  // command latch, loop counters and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur   <= cmd;
      rem   <= cmd.reps;
      total <= 5'd0;
    end else begin
      rem   <= rem_next;
      total <= total_next;
    end
    if (emit) res <= er;
  end

  // wait queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_id[qlen[QIDX_W-1:0]]  <= cur.tid;
      q_tmo[qlen[QIDX_W-1:0]] <= cur.tmo;
    end
    if (do_shift) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (j >= int'(shift_idx)) begin
          q_id[j]  <= q_id[j+1];
          q_tmo[j] <= q_tmo[j+1];
        end
      end
    end
    if (do_dec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i < int'(qlen) && q_tmo[i] != '0) q_tmo[i] <= q_tmo[i] - TMO_W'(1);
      end
    end
  end

endmodule

>>> rtl/counting_semaphore_timed_wait.sv
// top level of the counting semaphore with a timed fifo wait queue
// depends on csem_pkg, csem_front and csem_back
//
//   channel | signals                        | direction
//   request | req_valid, req_ready, req      | in
//   result  | res_valid, res_ready, res      | out
//   config  | cfg_we, cfg_wdata              | in
//
// wait and error requests give one result once the back end takes them
// signal gives a release per waiter, tick one per expiry, then a summary
// the back end works one request at a time, removing one waiter per release
// reset sets count 1, a config write sets cfg_wdata; both empty the queue
// the front queue takes requests while not full, even with results stalled
module counting_semaphore_timed_wait import csem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  csem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  csem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // summary results close the request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == K_SIG_DONE || res.kind == K_TICK_DONE) |-> res.last)
    else $error("summary result without last");

  // only releases come before the summary
  a_mid_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> (res.kind == K_SIG_REL || res.kind == K_TMO_REL))
    else $error("non-release result without last");

  // release total bounded by queue depth
  a_total: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.released_total <= 5'd16)
    else $error("release total too large");

  // a blocked waiter always leaves the count negative
  a_blocked_neg: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == K_BLOCKED |-> res.count_now < 16'sd0)
    else $error("blocked with nonnegative count");

endmodule

>>> dv/tb_counting_semaphore_timed_wait.sv
// testbench for the counting semaphore with a timed fifo wait queue
// depends on csem_pkg and counting_semaphore_timed_wait; predicts results internally
`timescale 1ns / 100ps

module tb_counting_semaphore_timed_wait;
  import csem_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;

  localparam int STALL_LIMIT = 20000;

  // model state of the semaphore
  int          sem_count;
  logic [3:0]  wq_id[$];
  logic [15:0] wq_tmo[$];
  res_t        expected_res[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          busy_pct = 20;

  counting_semaphore_timed_wait u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_res(kind_t k, logic [3:0] tid, logic [4:0] tot,
                                   logic l);
    res_t r;
    r.kind = k;
    r.released_thread = tid;
    r.released_total = tot;
    r.count_now = sem_count[15:0];
    r.last = l;
    expected_res.push_back(r);
  endfunction

  function automatic void count_up();
    if (sem_count < COUNT_MAX) sem_count++;
  endfunction

  // predict results of one request
  function automatic void predict_semaphore(req_t q);
    int reps, rel, i;
    logic [3:0] tid;
    case (q.opcode)
      OP_WAIT: begin
        if (sem_count > 0) begin
          sem_count--;
          push_res(K_GRANTED, q.thread_id, 5'd0, 1'b1);
        end else if (wq_id.size() >= QUEUE_DEPTH) begin
          push_res(K_ERROR, 4'd0, 5'd0, 1'b1);
        end else begin
          sem_count--;
          wq_id.push_back(q.thread_id);
          wq_tmo.push_back(q.timeout_ticks);
          push_res(K_BLOCKED, q.thread_id, 5'd0, 1'b1);
        end
      end
      OP_SIGNAL: begin
        if (q.signal_count < 0) begin
          push_res(K_ERROR, 4'd0, 5'd0, 1'b1);
        end else begin
          reps = (q.signal_count == 0) ? 1 : int'(q.signal_count);
          rel = 0;
          for (i = 0; i < reps; i++) begin
            if (sem_count < 0 && wq_id.size() > 0) begin
              count_up();
              tid = wq_id.pop_front();
              void'(wq_tmo.pop_front());
              rel++;
              push_res(K_SIG_REL, tid, 5'd0, 1'b0);
            end else begin
              count_up();
            end
          end
          push_res(K_SIG_DONE, 4'd0, rel[4:0], 1'b1);
        end
      end
      OP_TICK: begin
        i = 0;
        while (i < wq_id.size()) begin
          if (wq_tmo[i] != 0) begin
            wq_tmo[i]--;
            if (wq_tmo[i] == 0) begin
              tid = wq_id[i];
              wq_id.delete(i);
              wq_tmo.delete(i);
              count_up();
              push_res(K_TMO_REL, tid, 5'd0, 1'b0);
              continue;
            end
          end
          i++;
        end
        push_res(K_TICK_DONE, 4'd0, 5'd0, 1'b1);
      end
      default: push_res(K_ERROR, 4'd0, 5'd0, 1'b1);
    endcase
  endfunction

  // send one request, predict on acceptance; valid stays up for back to back requests
  task automatic send_req(logic [1:0] op, logic [3:0] tid, logic [15:0] tmo,
                          logic signed [7:0] sc);
    req_t q;
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    q.opcode = op;
    q.thread_id = tid;
    q.timeout_ticks = tmo;
    q.signal_count = sc;
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_semaphore(q);
  endtask

  // wait for drain, then let the back end settle
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_initial_count(logic [14:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sem_count = v;
    wq_id.delete();
    wq_tmo.delete();
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_tmo();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 4));
      default: return 16'($urandom());
    endcase
  endfunction

  // directed: every opcode and corner
  task automatic test_directed();
    int i;
    send_req(OP_WAIT, 4'd15, 16'd0, 8'sd0);
    send_req(OP_WAIT, 4'd1, 16'd2, -8'sd1);
    send_req(OP_WAIT, 4'd2, 16'd0, 8'sd0);
    send_req(OP_WAIT, 4'd3, 16'hFFFF, 8'sd127);
    send_req(OP_TICK, 4'd0, 16'd0, 8'sd0);
    send_req(OP_TICK, 4'd0, 16'd0, 8'sd0);
    send_req(OP_SIGNAL, 4'd0, 16'd0, 8'sd0);
    send_req(OP_SIGNAL, 4'd0, 16'd0, -8'sd128);
    send_req(2'd3, 4'hF, 16'hFFFF, 8'sd127);
    send_req(OP_SIGNAL, 4'd0, 16'd0, 8'sd127);
    write_initial_count(15'd0);
    for (i = 0; i < 17; i++) send_req(OP_WAIT, i[3:0], 16'(i), 8'sd0);
    send_req(OP_TICK, 4'd0, 16'd0, 8'sd0);
    send_req(OP_SIGNAL, 4'd0, 16'd0, 8'sd3);
  endtask

  // saturation at the top of the count
  task automatic test_saturation();
    write_initial_count(15'h7FFF);
    send_req(OP_SIGNAL, 4'd0, 16'd0, 8'sd5);
    send_req(OP_WAIT, 4'd7, 16'd0, 8'sd0);
    send_req(OP_SIGNAL, 4'd0, 16'd0, 8'sd0);
  endtask

  // random well formed traffic with some noise
  task automatic test_random(logic [14:0] init, int n);
    int i, r;
    write_initial_count(init);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      busy_pct = (i % 40 < 20) ? 0 : 30;
      if (r < 45)
        send_req(OP_WAIT, 4'($urandom()), rand_tmo(), 8'($urandom()));
      else if (r < 65)
        send_req(OP_SIGNAL, 4'($urandom()), 16'($urandom()),
                 8'($urandom_range(0, 4)));
      else if (r < 70)
        send_req(OP_SIGNAL, 4'($urandom()), 16'($urandom()), 8'($urandom()));
      else if (r < 95)
        send_req(OP_TICK, 4'($urandom()), 16'($urandom()), 8'($urandom()));
      else
        send_req(2'd3, 4'($urandom()), 16'($urandom()), 8'($urandom()));
    end
  endtask

  // result side: random stall, compare against oldest prediction
  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && res_ready) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result %p", res);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (res.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, res.kind); errors++;
        end
        if (res.released_thread !== e.released_thread) begin
          $error("released_thread exp %0d got %0d", e.released_thread,
                 res.released_thread); errors++;
        end
        if (res.released_total !== e.released_total) begin
          $error("released_total exp %0d got %0d", e.released_total,
                 res.released_total); errors++;
        end
        if (res.count_now !== e.count_now) begin
          $error("count_now exp %0d got %0d", e.count_now, res.count_now);
          errors++;
        end
        if (res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, res.last); errors++;
        end
      end
    end
    if ($urandom_range(0, 99) < 3)
      res_ready <= 1'b0;
    else if ($urandom_range(0, 99) >= busy_pct)
      res_ready <= 1'b1;
    else
      res_ready <= 1'b0;
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sem_count = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random(15'd0, 70);
    test_random(15'd2, 60);
    test_random(15'd1, 40);
    drain();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/csem_pkg.sv
rtl/csem_front.sv
rtl/csem_back.sv
rtl/counting_semaphore_timed_wait.sv
dv/tb_counting_semaphore_timed_wait.sv
